// ===== rtl/lfbd_pkg.sv =====
// lfbd_pkg: shared constants, types and command/status structs of the lzss flag-byte decoder
`timescale 1ns / 1ps

package lfbd_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int COUNT_WIDTH_DEF = 24;

    localparam int BYTE_W     = 8;
    localparam int LIMIT_W    = 24;
    localparam int DIST_W     = 12;
    localparam int LEN_W      = 5;
    localparam int LEN_BIAS   = 3;
    localparam int FLAG_BITS  = 8;
    localparam int FLAG_IDX_W = 3;
    localparam int BIT_IDX_W  = 4;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_HIGH
    } t_phase;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SKIP,
        OP_FLAG,
        OP_LIT,
        OP_LOW,
        OP_REF,
        OP_EMPTY
    } t_op;

    typedef struct packed {
        logic accept;
        t_op  op;
        logic rd_issue;
        logic emit_copy;
    } t_cmd;

    typedef struct packed {
        logic   skip;
        t_phase phase;
        logic   flag_bit;
        logic   ref_ok;
        logic   slot_free;
        logic   copy_final;
    } t_status;

endpackage

// ===== rtl/lfbd_ram.sv =====
// lfbd_ram: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lfbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lfbd_ctrl.sv =====
// lfbd_ctrl: controller state machine that sequences token decode and history copies
`timescale 1ns / 1ps

module lfbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lfbd_pkg::t_status i_status,
    output lfbd_pkg::t_cmd    o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rd_pend;
    logic   n_rd_pend;

    logic         needs_slot;
    logic         ready;
    logic         accept;
    logic         emit_copy;
    logic         rd_issue;
    lfbd_pkg::t_op op;

    assign needs_slot = !i_status.skip && (i_status.phase == lfbd_pkg::PH_TOKEN)
                        && i_status.flag_bit;
    assign ready      = (r_state == ST_IDLE) && (!needs_slot || i_status.slot_free);
    assign accept     = i_in_valid && ready;
    assign emit_copy  = (r_state == ST_COPY) && r_rd_pend && i_status.slot_free;
    assign rd_issue   = (r_state == ST_COPY)
                        && (!r_rd_pend || (emit_copy && !i_status.copy_final));

    always_comb begin
        op = lfbd_pkg::OP_NONE;
        if (accept) begin
            priority if (i_status.skip) begin
                op = lfbd_pkg::OP_SKIP;
            end else if (i_status.phase == lfbd_pkg::PH_FLAG) begin
                op = lfbd_pkg::OP_FLAG;
            end else if (i_status.phase == lfbd_pkg::PH_TOKEN) begin
                op = i_status.flag_bit ? lfbd_pkg::OP_LIT : lfbd_pkg::OP_LOW;
            end else begin
                op = i_status.ref_ok ? lfbd_pkg::OP_REF : lfbd_pkg::OP_EMPTY;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_rd_pend = r_rd_pend;
        unique case (r_state)
            ST_IDLE: begin
                if (op == lfbd_pkg::OP_REF) begin
                    n_state   = ST_COPY;
                    n_rd_pend = 1'b0;
                end
            end
            ST_COPY: begin
                if (emit_copy && i_status.copy_final) begin
                    n_state   = ST_IDLE;
                    n_rd_pend = 1'b0;
                end else if (rd_issue) begin
                    n_rd_pend = 1'b1;
                end
            end
            default: begin
                n_state   = ST_IDLE;
                n_rd_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
        end
    end

    assign o_in_ready      = ready;
    assign o_cmd.accept    = accept;
    assign o_cmd.op        = op;
    assign o_cmd.rd_issue  = rd_issue;
    assign o_cmd.emit_copy = emit_copy;

endmodule

// ===== rtl/lfbd_dpath.sv =====
// lfbd_dpath: token registers, counters, history ram and output register
`timescale 1ns / 1ps

module lfbd_dpath #(
    parameter int WINDOW_SIZE = lfbd_pkg::WINDOW_SIZE_DEF,
    parameter int COUNT_WIDTH = lfbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lfbd_pkg::t_cmd               i_cmd,
    output lfbd_pkg::t_status            o_status,
    input  logic [lfbd_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                         i_in_last,
    input  logic                         i_cfg_wr_en,
    input  logic [lfbd_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [lfbd_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_out_last,
    output logic                         o_out_done
);

    localparam int AW    = $clog2(WINDOW_SIZE);
    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (CW > lfbd_pkg::LIMIT_W) ? CW : lfbd_pkg::LIMIT_W;
    localparam int DC_W  = (CW > lfbd_pkg::DIST_W) ? CW : lfbd_pkg::DIST_W;
    localparam int WD_W  = lfbd_pkg::DIST_W + 1;
    localparam int BW    = lfbd_pkg::BYTE_W;
    localparam int BIW   = lfbd_pkg::BIT_IDX_W;
    localparam int LW    = lfbd_pkg::LEN_W;

    // stream state
    logic [lfbd_pkg::LIMIT_W-1:0] r_limit;
    logic [AW-1:0]                r_wp,        n_wp;
    logic [CW-1:0]                r_count,     n_count;
    logic [BW-1:0]                r_flags,     n_flags;
    logic [BIW-1:0]               r_bit_idx,   n_bit_idx;
    lfbd_pkg::t_phase             r_phase,     n_phase;
    logic [BW-1:0]                r_ref_low,   n_ref_low;
    logic                         r_limit_hit, n_limit_hit;

    // copy and output registers
    logic [AW-1:0] r_src;
    logic [LW-1:0] r_remain;
    logic          r_last;
    logic          r_fwd_hit;
    logic [BW-1:0] r_fwd_data;
    logic          r_o_valid;
    logic [BW-1:0] r_o_byte;
    logic          r_o_last;
    logic          r_o_done;

    logic [CW-1:0]                 count_inc;
    logic                          can_now;
    logic                          can_next;
    logic                          done_next;
    logic [lfbd_pkg::DIST_W-1:0]   ref_dist;
    logic [LW-1:0]                 len;
    logic                          ref_ok;
    logic [AW:0]                   src_sum;
    logic [AW-1:0]                 src_start;
    logic [AW-1:0]                 wp_inc;
    logic [AW-1:0]                 src_inc;
    logic [BIW-1:0]                bit_inc;
    lfbd_pkg::t_phase              tok_phase;
    logic                          lit_emit;
    logic                          emit;
    logic                          copy_final;
    logic                          slot_free;
    logic [BW-1:0]                 ram_q;
    logic [BW-1:0]                 copy_byte;
    logic [BW-1:0]                 wr_data;

    assign count_inc = r_count + CW'(1);
    assign can_now   = (CMP_W'(r_count) < CMP_W'(r_limit)) && (r_count != {CW{1'b1}});
    assign can_next  = (CMP_W'(count_inc) < CMP_W'(r_limit)) && (count_inc != {CW{1'b1}});
    assign done_next = CMP_W'(count_inc) >= CMP_W'(r_limit);

    assign ref_dist = {i_in_byte, r_ref_low[7:4]};
    assign len      = LW'(r_ref_low[3:0]) + LW'(lfbd_pkg::LEN_BIAS);
    assign ref_ok   = (ref_dist != '0) && (DC_W'(ref_dist) <= DC_W'(r_count))
                      && (WD_W'(ref_dist) <= WD_W'(WINDOW_SIZE));

    // source = (write position - distance) modulo the window
    assign src_sum   = (AW+1)'(r_wp) + (AW+1)'(WINDOW_SIZE) - (AW+1)'(ref_dist);
    assign src_start = (src_sum >= (AW+1)'(WINDOW_SIZE))
                       ? AW'(src_sum - (AW+1)'(WINDOW_SIZE)) : AW'(src_sum);
    assign wp_inc    = (r_wp == AW'(WINDOW_SIZE - 1)) ? '0 : r_wp + AW'(1);
    assign src_inc   = (r_src == AW'(WINDOW_SIZE - 1)) ? '0 : r_src + AW'(1);

    assign bit_inc   = r_bit_idx + BIW'(1);
    assign tok_phase = (bit_inc >= BIW'(lfbd_pkg::FLAG_BITS))
                       ? lfbd_pkg::PH_FLAG : lfbd_pkg::PH_TOKEN;

    assign lit_emit   = i_cmd.accept && (i_cmd.op == lfbd_pkg::OP_LIT);
    assign emit       = lit_emit || i_cmd.emit_copy;
    assign copy_final = (r_remain == LW'(1)) || !can_next;
    assign slot_free  = !r_o_valid || i_out_ready;
    assign copy_byte  = r_fwd_hit ? r_fwd_data : ram_q;
    assign wr_data    = i_cmd.emit_copy ? copy_byte : i_in_byte;

    lfbd_ram #(
        .WIDTH (BW),
        .DEPTH (WINDOW_SIZE)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (emit),
        .i_wr_addr (r_wp),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_src),
        .o_rd_data (ram_q)
    );

    always_comb begin
        n_wp        = r_wp;
        n_count     = r_count;
        n_flags     = r_flags;
        n_bit_idx   = r_bit_idx;
        n_phase     = r_phase;
        n_ref_low   = r_ref_low;
        n_limit_hit = r_limit_hit;

        if (emit) begin
            n_wp    = wp_inc;
            n_count = count_inc;
            if (!can_next) begin
                n_limit_hit = 1'b1;
            end
        end

        if (i_cmd.accept) begin
            unique case (i_cmd.op)
                lfbd_pkg::OP_SKIP: begin
                    n_limit_hit = 1'b1;
                end
                lfbd_pkg::OP_FLAG: begin
                    n_flags   = i_in_byte;
                    n_bit_idx = '0;
                    n_phase   = lfbd_pkg::PH_TOKEN;
                end
                lfbd_pkg::OP_LIT, lfbd_pkg::OP_EMPTY: begin
                    n_bit_idx = bit_inc;
                    n_phase   = tok_phase;
                end
                lfbd_pkg::OP_LOW: begin
                    n_ref_low = i_in_byte;
                    n_phase   = lfbd_pkg::PH_HIGH;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.emit_copy && copy_final) begin
            n_bit_idx = bit_inc;
            n_phase   = tok_phase;
        end

        // end of stream: back to the start
        if ((i_cmd.accept && i_in_last && (i_cmd.op != lfbd_pkg::OP_REF))
            || (i_cmd.emit_copy && copy_final && r_last)) begin
            n_wp        = '0;
            n_count     = '0;
            n_flags     = '0;
            n_bit_idx   = BIW'(lfbd_pkg::FLAG_BITS);
            n_phase     = lfbd_pkg::PH_FLAG;
            n_ref_low   = '0;
            n_limit_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_flags     <= '0;
            r_bit_idx   <= BIW'(lfbd_pkg::FLAG_BITS);
            r_phase     <= lfbd_pkg::PH_FLAG;
            r_ref_low   <= '0;
            r_limit_hit <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_flags     <= n_flags;
            r_bit_idx   <= n_bit_idx;
            r_phase     <= n_phase;
            r_ref_low   <= n_ref_low;
            r_limit_hit <= n_limit_hit;
            if (i_cmd.rd_issue) begin
                r_fwd_hit <= i_cmd.emit_copy && (r_src == r_wp);
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_cmd.op == lfbd_pkg::OP_REF)) begin
            r_src    <= src_start;
            r_remain <= len;
            r_last   <= i_in_last;
        end else begin
            if (i_cmd.rd_issue) begin
                r_src      <= src_inc;
                r_fwd_data <= wr_data;
            end
            if (i_cmd.emit_copy) begin
                r_remain <= r_remain - LW'(1);
            end
        end
        if (emit) begin
            r_o_byte <= wr_data;
            r_o_last <= lit_emit || copy_final;
            r_o_done <= done_next;
        end
    end

    assign o_status.skip       = r_limit_hit || !can_now;
    assign o_status.phase      = r_phase;
    assign o_status.flag_bit   = r_flags[r_bit_idx[lfbd_pkg::FLAG_IDX_W-1:0]];
    assign o_status.ref_ok     = ref_ok;
    assign o_status.slot_free  = slot_free;
    assign o_status.copy_final = copy_final;

    assign o_out_valid = r_o_valid;
    assign o_out_byte  = r_o_byte;
    assign o_out_last  = r_o_last;
    assign o_out_done  = r_o_done;

endmodule

// ===== rtl/lzss_flag_byte_decoder_unit.sv =====
// lzss_flag_byte_decoder_unit: top level of the lzss flag-byte decoder
//
// channel | direction | handshake                    | word
// --------+-----------+------------------------------+----------------------------------
// in      | input     | i_in_valid / o_in_ready      | i_in_byte, i_in_last
// out     | output    | o_out_valid / i_out_ready    | o_out_byte, o_out_last, o_out_done
// cfg     | input     | i_cfg_wr_en (no wait)        | i_cfg_wr_data (output limit)
//
// a flag byte, low byte, literal, skipped word or empty reference is done when it is accepted;
// a copying reference runs as: accept, first history read, then one byte per cycle
// while the output slot is free, from the single history read port
// i_rst_n is synchronous; the history ram is not cleared, so no sweep follows reset
// a held output word stalls literals and copies; other input words are still taken
`timescale 1ns / 1ps

module lzss_flag_byte_decoder_unit #(
    parameter int WINDOW_SIZE = lfbd_pkg::WINDOW_SIZE_DEF,
    parameter int COUNT_WIDTH = lfbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lfbd_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                         i_in_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lfbd_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_out_last,
    output logic                         o_out_done,
    input  logic                         i_cfg_wr_en,
    input  logic [lfbd_pkg::LIMIT_W-1:0] i_cfg_wr_data
);

    lfbd_pkg::t_cmd    cmd;
    lfbd_pkg::t_status status;

    lfbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lfbd_dpath #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_out_done    (o_out_done)
    );

    // reaching the limit always ends the word group of an input
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_done |-> o_out_last)
        else $error("done word without last");

    // no input is taken while a copy runs
    a_no_accept_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_copy || cmd.rd_issue) |-> !cmd.accept)
        else $error("input accepted during copy");

    // a valid reference starts a copy and blocks input next cycle
    a_ref_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept && (cmd.op == lfbd_pkg::OP_REF) |=> !o_in_ready && cmd.rd_issue)
        else $error("copy did not start after reference");

endmodule

// ===== verif/lzss_flag_byte_decoder_unit_tb.sv =====
// lzss_flag_byte_decoder_unit_tb: self-checking testbench of the lzss flag-byte decoder unit
`timescale 1ns / 1ps

module lzss_flag_byte_decoder_unit_tb;

    localparam int BYTE_W       = lfbd_pkg::BYTE_W;
    localparam int DIST_W       = lfbd_pkg::DIST_W;
    localparam int LIMIT_W      = lfbd_pkg::LIMIT_W;
    localparam int FLAG_BITS    = lfbd_pkg::FLAG_BITS;
    localparam int FLAG_IDX_W   = lfbd_pkg::FLAG_IDX_W;
    localparam int BIT_IDX_W    = lfbd_pkg::BIT_IDX_W;
    localparam int LEN_BIAS     = lfbd_pkg::LEN_BIAS;
    localparam int HIST_DEPTH   = lfbd_pkg::WINDOW_SIZE_DEF;

    localparam int DIRECTED_N   = 29;
    localparam int RANDOM_WORDS = 220;
    localparam int PHASE_WORDS  = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int NOISE_PCT    = 5;
    localparam int REPORT_MAX   = 200;
    localparam int DIST_MAX     = (1 << DIST_W) - 1;
    localparam int TIMEOUT_NS   = 2000000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              done;
    } t_out_word;

    class t_lzss_scoreboard;
        logic [BYTE_W-1:0]    hist [HIST_DEPTH];
        logic [DIST_W-1:0]    wr_pos;
        logic [LIMIT_W-1:0]   produced;
        logic [LIMIT_W-1:0]   limit;
        logic [FLAG_BITS-1:0] flags;
        logic [BIT_IDX_W-1:0] bit_idx;
        lfbd_pkg::t_phase     phase;
        logic [BYTE_W-1:0]    ref_low;
        logic                 limit_hit;
        t_out_word            expected_q[$];
        int                   errors;
        int                   accepted;

        function new();
            limit = '0;
            errors = 0;
            accepted = 0;
            restart();
        endfunction

        function void restart();
            wr_pos = '0;
            produced = '0;
            flags = '0;
            bit_idx = BIT_IDX_W'(FLAG_BITS);
            phase = lfbd_pkg::PH_FLAG;
            ref_low = '0;
            limit_hit = 1'b0;
        endfunction

        function bit room();
            return produced < limit && produced != {LIMIT_W{1'b1}};
        endfunction

        function void push_byte(logic [BYTE_W-1:0] b);
            t_out_word w;
            hist[wr_pos] = b;
            wr_pos++;
            produced++;
            w.data = b;
            w.last = 1'b0;
            w.done = produced >= limit;
            expected_q.insert(expected_q.size(), w);
        endfunction

        function void next_token();
            bit_idx++;
            phase = (bit_idx >= FLAG_BITS) ? lfbd_pkg::PH_FLAG : lfbd_pkg::PH_TOKEN;
        endfunction

        function void note_input(logic [BYTE_W-1:0] b, logic last);
            int                    n0;
            logic [2*BYTE_W-1:0]   ref_word;
            logic [DIST_W-1:0]     distance;
            int                    len;
            n0 = expected_q.size();
            accepted++;
            if (limit_hit || !room()) begin
                limit_hit = 1'b1;
            end else begin
                case (phase)
                    lfbd_pkg::PH_FLAG: begin
                        flags = b;
                        bit_idx = '0;
                        phase = lfbd_pkg::PH_TOKEN;
                    end
                    lfbd_pkg::PH_TOKEN: begin
                        if (flags[bit_idx[FLAG_IDX_W-1:0]]) begin
                            push_byte(b);
                            next_token();
                        end else begin
                            ref_low = b;
                            phase = lfbd_pkg::PH_HIGH;
                        end
                    end
                    lfbd_pkg::PH_HIGH: begin
                        ref_word = {b, ref_low};
                        distance = ref_word[2*BYTE_W-1:2*BYTE_W-DIST_W];
                        len = ref_word[3:0] + LEN_BIAS;
                        if (distance != 0 && distance <= produced) begin
                            for (int i = 0; i < len && room(); i++) begin
                                push_byte(hist[wr_pos - distance]);
                            end
                        end
                        next_token();
                    end
                    default: ;
                endcase
            end
            if (!room()) limit_hit = 1'b1;
            if (expected_q.size() > n0) expected_q[expected_q.size()-1].last = 1'b1;
            if (last) restart();
        endfunction

        function void check_result(logic [BYTE_W-1:0] b, logic last, logic done);
            t_out_word w;
            if (expected_q.size() == 0) begin
                if (errors < REPORT_MAX) begin
                    $display("%0t ns: unexpected out word byte=%h last=%b done=%b",
                             $time, b, last, done);
                end
                errors++;
            end else begin
                w = expected_q.pop_front();
                if (b !== w.data || last !== w.last || done !== w.done) begin
                    if (errors < REPORT_MAX) begin
                        $display(
                            "%0t ns: expected byte=%h last=%b done=%b, got %h %b %b",
                            $time, w.data, w.last, w.done, b, last, done);
                    end
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_in_byte;
    logic                 i_in_last;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_out_last;
    logic                 o_out_done;
    logic                 i_cfg_wr_en;
    logic [LIMIT_W-1:0]   i_cfg_wr_data;

    t_lzss_scoreboard     sb;
    logic [BYTE_W-1:0]    plan_high;
    int                   stream_left;
    bit                   no_idle;
    bit                   hold_req;

    logic [BYTE_W:0] directed_words [DIRECTED_N] = '{
        9'h0FD, 9'h000, 9'h01F, 9'h000, 9'h0FF, 9'h080, 9'h001, 9'h07F, 9'h0AA, 9'h055,
        9'h000, 9'h005, 9'h000, 9'h0FF, 9'h0FF, 9'h090, 9'h001, 9'h0C0, 9'h001, 9'h134,
        9'h0FF, 9'h142,
        9'h0FF, 9'h012, 9'h134,
        9'h001, 9'h05A, 9'h01F, 9'h100
    };

    lzss_flag_byte_decoder_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_out_done    (o_out_done),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("lzss_flag_byte_decoder_unit_tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_input(i_in_byte, i_in_last);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_byte, o_out_last, o_out_done);
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int gap_left;
        int r;
        i_out_ready = 1'b0;
        gap_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
            end else if (gap_left > 0) begin
                i_out_ready <= 1'b0;
                gap_left--;
            end else begin
                i_out_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 12) gap_left = $urandom_range(1, 3);
                else if (r < 15) gap_left = $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_stream_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(1, 4);
        if (r < 90) return $urandom_range(5, 60);
        return $urandom_range(100, 200);
    endfunction

    task automatic send_word(input logic [BYTE_W-1:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_in_last <= l;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        sb.limit = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed tokens built from the predicted stream state
    task automatic next_word(output logic [BYTE_W-1:0] b, output logic l);
        int                r;
        int                r2;
        int                span;
        logic [DIST_W-1:0] distance;
        logic [3:0]        len_code;
        r = $urandom_range(0, 99);
        r2 = $urandom_range(0, 99);
        b = BYTE_W'($urandom);
        if (r >= NOISE_PCT) begin
            case (sb.phase)
                lfbd_pkg::PH_FLAG: begin
                    if (r < 40) b = BYTE_W'($urandom & $urandom);
                end
                lfbd_pkg::PH_TOKEN: begin
                    if (!sb.flags[sb.bit_idx[FLAG_IDX_W-1:0]]) begin
                        len_code = 4'($urandom);
                        if (sb.produced == 0 || r2 < 15) begin
                            if (r2 < 6 || sb.produced >= DIST_MAX) distance = '0;
                            else distance = DIST_W'($urandom_range(sb.produced + 1, DIST_MAX));
                        end else begin
                            span = (sb.produced > DIST_MAX) ? DIST_MAX : sb.produced;
                            if (span > 40 && r2 < 70) span = 40;
                            distance = DIST_W'($urandom_range(1, span));
                        end
                        b = {distance[3:0], len_code};
                        plan_high = distance[DIST_W-1:4];
                    end
                end
                lfbd_pkg::PH_HIGH: b = plan_high;
                default: ;
            endcase
        end
        stream_left--;
        l = (stream_left <= 0) || (sb.limit_hit && $urandom_range(0, 3) == 0);
        if (l) stream_left = pick_stream_len();
    endtask

    initial begin
        logic [BYTE_W-1:0]  b;
        logic               l;
        logic [LIMIT_W-1:0] lim;
        int                 base;
        int                 seg;
        int                 phase_no;
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte = '0;
        i_in_last = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        plan_high = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        stream_left = pick_stream_len();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: literals, long copy, zero and too-far distances, cut-off reference,
        // then limits of zero, one and a copy cut short
        set_limit({LIMIT_W{1'b1}});
        for (int i = 0; i < DIRECTED_N; i++) begin
            if (i == 20) begin
                wait_drained();
                set_limit('0);
            end else if (i == 22) begin
                wait_drained();
                set_limit(LIMIT_W'(1));
            end else if (i == 25) begin
                wait_drained();
                set_limit(LIMIT_W'(10));
            end
            send_word(directed_words[i][BYTE_W-1:0], directed_words[i][BYTE_W]);
        end
        wait_drained();

        base = sb.accepted;
        phase_no = 0;
        while (sb.accepted - base < RANDOM_WORDS) begin
            case (phase_no % 5)
                0: lim = {LIMIT_W{1'b1}};
                1: lim = LIMIT_W'(1);
                2: lim = LIMIT_W'($urandom_range(2, 40));
                3: lim = LIMIT_W'($urandom_range(41, 800));
                default: lim = LIMIT_W'($urandom);
            endcase
            set_limit(lim);
            no_idle = (phase_no % 4 == 3);
            if (phase_no == 0) hold_req = 1'b1;
            seg = sb.accepted;
            while (sb.accepted - seg < PHASE_WORDS && sb.accepted - base < RANDOM_WORDS) begin
                next_word(b, l);
                send_word(b, l);
            end
            wait_drained();
            phase_no++;
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("lzss_flag_byte_decoder_unit_tb OK");
        end else begin
            $display("lzss_flag_byte_decoder_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
